[hw/rtl/lsct_pkg.sv]
// lsct_pkg: shared types, constants and the weight table of the line sensor
// centroid tracker. No dependencies.

package lsct_pkg;

  localparam int unsigned CHANNELS_DEF = 8;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned QUERY_W  = 3;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned STATE_W  = 8;
  localparam int unsigned AREG_W   = 5;
  localparam int unsigned TREG_W   = 6;
  localparam int unsigned SUM_W    = 14;

  // stream packing
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 136;

  // read kinds
  localparam logic [KIND_W-1:0] KIND_STATE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ANALOG = 2'd1;
  localparam logic [KIND_W-1:0] KIND_THRESH = 2'd2;

  localparam int unsigned ANALOG_BASE    = 6;
  localparam int unsigned THRESHOLD_BASE = 22;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;
  localparam logic [LIMIT_W-1:0] ERR_SAT     = 8'd255;

  // bit-serial steps
  localparam int unsigned ACC_STEPS = 8;
  localparam int unsigned DIV_STEPS = SUM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ACCUM,
    CS_SIGN,
    CS_DIVIDE
  } cent_state_e;

  typedef struct packed {
    logic                    done;
    logic signed [POS_W-1:0] position;
    logic [CNT_W-1:0]        active;
  } cent_rsp_t;

  // sensor weight, bit 0 is leftmost
  function automatic logic signed [SUM_W-1:0] weight(input logic [2:0] idx);
    logic signed [SUM_W-1:0] w;
    case (idx)
      3'd0:    w = -14'sd3500;
      3'd1:    w = -14'sd2500;
      3'd2:    w = -14'sd1500;
      3'd3:    w = -14'sd500;
      3'd4:    w = 14'sd500;
      3'd5:    w = 14'sd1500;
      3'd6:    w = 14'sd2500;
      3'd7:    w = 14'sd3500;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/lsct_centroid.sv]
// lsct_centroid: bit-serial weighted centroid of the 8-bit state byte.
// Accumulates one sensor bit per cycle, then restoring division one quotient
// bit per cycle. Depends on lsct_pkg.

module lsct_centroid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          bits_i,
  output lsct_pkg::cent_rsp_t rsp_o
);

  lsct_pkg::cent_state_e state_q, state_d;

  logic [3:0]                        step_q, step_d;
  logic [7:0]                        bits_q, bits_d;
  logic signed [lsct_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [lsct_pkg::CNT_W-1:0]        n_q, n_d;
  logic                              neg_q, neg_d;
  logic [3:0]                        rem_q, rem_d;
  logic [lsct_pkg::SUM_W-1:0]        dvd_q, dvd_d;

  logic [4:0]                 trial;
  logic                       qbit;
  logic [lsct_pkg::POS_W-1:0] quot;
  logic                       acc_last;
  logic                       div_last;

  assign trial    = {rem_q, dvd_q[lsct_pkg::SUM_W-1]};
  assign qbit     = (trial >= {1'b0, n_q});
  assign quot     = {dvd_q[lsct_pkg::POS_W-2:0], qbit};
  assign acc_last = (step_q == 4'(lsct_pkg::ACC_STEPS - 1));
  assign div_last = (step_q == 4'(lsct_pkg::DIV_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lsct_pkg::CS_IDLE:   if (start_i) state_d = lsct_pkg::CS_ACCUM;
      lsct_pkg::CS_ACCUM:  if (acc_last) state_d = lsct_pkg::CS_SIGN;
      lsct_pkg::CS_SIGN:   state_d = lsct_pkg::CS_DIVIDE;
      lsct_pkg::CS_DIVIDE: if (div_last) state_d = lsct_pkg::CS_IDLE;
      default:             state_d = lsct_pkg::CS_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    step_d = step_q;
    bits_d = bits_q;
    sum_d  = sum_q;
    n_d    = n_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    case (state_q)
      lsct_pkg::CS_IDLE: begin
        step_d = '0;
        bits_d = bits_i;
        sum_d  = '0;
        n_d    = '0;
      end
      lsct_pkg::CS_ACCUM: begin
        if (bits_q[0]) begin
          sum_d = sum_q + lsct_pkg::weight(step_q[2:0]);
          n_d   = n_q + 4'd1;
        end
        bits_d = {1'b0, bits_q[7:1]};
        step_d = acc_last ? 4'd0 : step_q + 4'd1;
      end
      lsct_pkg::CS_SIGN: begin
        neg_d = sum_q[lsct_pkg::SUM_W-1];
        dvd_d = sum_q[lsct_pkg::SUM_W-1] ? lsct_pkg::SUM_W'(-sum_q)
                                         : lsct_pkg::SUM_W'(sum_q);
        rem_d = '0;
      end
      lsct_pkg::CS_DIVIDE: begin
        rem_d  = qbit ? 4'(trial - {1'b0, n_q}) : trial[3:0];
        dvd_d  = {dvd_q[lsct_pkg::SUM_W-2:0], qbit};
        step_d = step_q + 4'd1;
      end
      default: ;
    endcase
  end

  // response
  always_comb begin
    rsp_o.done   = (state_q == lsct_pkg::CS_DIVIDE) && div_last;
    rsp_o.active = n_q;
    if (n_q == '0) begin
      rsp_o.position = '0;
    end else if (neg_q) begin
      rsp_o.position = -$signed(quot);
    end else begin
      rsp_o.position = $signed(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsct_pkg::CS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    sum_q  <= sum_d;
    n_q    <= n_d;
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
  end

endmodule

[hw/rtl/line_sensor_centroid_tracker_top.sv]
// Line sensor centroid tracker: a good state-byte read goes through bit-serial
// accumulation, a sign step and one-bit-per-cycle division in lsct_centroid, and
// its result is then loaded into the output register once that register is free;
// analog, threshold, failed and unused reads skip the centroid and wait only for the
// output register. One item is in flight at a time; a new beat is accepted while the
// previous result waits in the output register.
// Depends on lsct_pkg and lsct_centroid.

module line_sensor_centroid_tracker_top #(
  parameter int unsigned CHANNELS = lsct_pkg::CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lsct_pkg::LIMIT_W-1:0]       cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] read_data, [18:16] query_channel, [23:19] zero
  input  logic [lsct_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] kind, [2] read_ok
  input  logic [lsct_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [12:0] position, [16:13] lit_count, [17] no_line, [18] connected,
  // [50:19] good_reads, [82:51] error_total, [90:83] state_bits,
  // [95:91] next_analog_register, [101:96] next_threshold_register,
  // [117:102] analog_at_query, [133:118] threshold_at_query, [135:134] zero
  output logic [lsct_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned CH_W = $clog2(CHANNELS);

  lsct_pkg::top_state_e state_q, state_d;

  logic [lsct_pkg::LIMIT_W-1:0]      limit_q;
  logic [lsct_pkg::LIMIT_W-1:0]      cons_q;
  logic                              conn_q;
  logic [lsct_pkg::SEQ_W-1:0]        seq_q;
  logic [lsct_pkg::SEQ_W-1:0]        err_q;
  logic [lsct_pkg::STATE_W-1:0]      last_q;
  logic signed [lsct_pkg::POS_W-1:0] pos_q;
  logic [lsct_pkg::CNT_W-1:0]        act_q;
  logic                              lost_q;
  logic [CH_W-1:0]                   ach_q;
  logic [CH_W-1:0]                   tch_q;
  logic [CH_W-1:0]                   query_q;
  logic [lsct_pkg::DATA_W-1:0]       astore_q [CHANNELS];
  logic [lsct_pkg::DATA_W-1:0]       tstore_q [CHANNELS];
  logic                              out_vld_q;
  logic [lsct_pkg::M_TDATA_W-1:0]    out_data_q;

  logic [lsct_pkg::KIND_W-1:0] in_kind;
  logic                        in_ok;
  logic [lsct_pkg::DATA_W-1:0] in_data;
  logic [CH_W-1:0]             in_query;
  logic                        in_acc;
  logic                        good_state;
  logic                        good_analog;
  logic                        good_thresh;
  logic                        fail;
  logic                        out_free;
  logic                        load_out;
  logic                        cent_start;
  logic [lsct_pkg::LIMIT_W-1:0] cons_inc;
  logic [lsct_pkg::AREG_W-1:0] next_areg;
  logic [lsct_pkg::TREG_W-1:0] next_treg;
  logic [lsct_pkg::M_TDATA_W-1:0] out_word;
  lsct_pkg::cent_rsp_t         cent_rsp;

  assign in_kind  = s_axis_tuser[lsct_pkg::KIND_W-1:0];
  assign in_ok    = s_axis_tuser[lsct_pkg::KIND_W];
  assign in_data  = s_axis_tdata[lsct_pkg::DATA_W-1:0];
  assign in_query = s_axis_tdata[lsct_pkg::DATA_W +: CH_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  assign good_state  = in_acc && in_ok && (in_kind == lsct_pkg::KIND_STATE);
  assign good_analog = in_acc && in_ok && (in_kind == lsct_pkg::KIND_ANALOG);
  assign good_thresh = in_acc && in_ok && (in_kind == lsct_pkg::KIND_THRESH);
  assign fail        = in_acc && !in_ok &&
                       ((in_kind == lsct_pkg::KIND_STATE) ||
                        (in_kind == lsct_pkg::KIND_ANALOG) ||
                        (in_kind == lsct_pkg::KIND_THRESH));

  assign cons_inc = (cons_q == lsct_pkg::ERR_SAT) ? cons_q : cons_q + 8'd1;
  assign out_free = !out_vld_q || m_axis_tready;

  assign next_areg = lsct_pkg::AREG_W'(lsct_pkg::ANALOG_BASE) +
                     lsct_pkg::AREG_W'({ach_q, 1'b0});
  assign next_treg = lsct_pkg::TREG_W'(lsct_pkg::THRESHOLD_BASE) +
                     lsct_pkg::TREG_W'({tch_q, 1'b0});

  assign out_word = {2'b00, tstore_q[query_q], astore_q[query_q], next_treg, next_areg,
                     last_q, err_q, seq_q, conn_q, lost_q, act_q, pos_q};

  lsct_centroid u_centroid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cent_start),
    .bits_i (in_data[lsct_pkg::STATE_W-1:0]),
    .rsp_o  (cent_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lsct_pkg::ST_IDLE: begin
        if (in_acc) state_d = good_state ? lsct_pkg::ST_CALC : lsct_pkg::ST_EMIT;
      end
      lsct_pkg::ST_CALC: if (cent_rsp.done) state_d = lsct_pkg::ST_EMIT;
      lsct_pkg::ST_EMIT: if (out_free) state_d = lsct_pkg::ST_IDLE;
      default:           state_d = lsct_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      lsct_pkg::ST_IDLE: s_axis_tready = 1'b1;
      lsct_pkg::ST_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  assign cent_start = good_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lsct_pkg::ST_IDLE;
      limit_q   <= lsct_pkg::LIMIT_RESET;
      cons_q    <= '0;
      conn_q    <= 1'b0;
      seq_q     <= '0;
      err_q     <= '0;
      last_q    <= '0;
      pos_q     <= '0;
      act_q     <= '0;
      lost_q    <= 1'b1;
      ach_q     <= '0;
      tch_q     <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        astore_q[i] <= '0;
        tstore_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (good_state) begin
        last_q <= in_data[lsct_pkg::STATE_W-1:0];
        conn_q <= 1'b1;
        seq_q  <= seq_q + 32'd1;
        cons_q <= '0;
      end
      if (fail) begin
        err_q  <= err_q + 32'd1;
        cons_q <= cons_inc;
        if (cons_inc >= limit_q) conn_q <= 1'b0;
      end
      if (good_analog) begin
        astore_q[ach_q] <= in_data;
        ach_q <= (ach_q == CH_W'(CHANNELS - 1)) ? '0 : ach_q + 1'b1;
      end
      if (good_thresh) begin
        tstore_q[tch_q] <= in_data;
        tch_q <= (tch_q == CH_W'(CHANNELS - 1)) ? '0 : tch_q + 1'b1;
      end
      if (cent_rsp.done) begin
        pos_q  <= cent_rsp.position;
        act_q  <= cent_rsp.active;
        lost_q <= (cent_rsp.active == '0);
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) query_q <= in_query;
    if (load_out) out_data_q <= out_word;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // lost flag always agrees with the active count
  a_lost_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_q == (act_q == '0))
    else $error("lost flag disagrees with lit count");

  // centroid finishes only while the sequencer waits for it
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cent_rsp.done |-> (state_q == lsct_pkg::ST_CALC))
    else $error("centroid done outside calc state");

  // a good state read reconnects and clears the error run
  a_good_state_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_state |=> (cons_q == '0) && conn_q)
    else $error("good state read did not clear error run");

  // the output register is never overwritten while a beat is stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_vld_q || m_axis_tready))
    else $error("result register overwritten while stalled");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for line_sensor_centroid_tracker_top. A short
// table of read beats, then random phases under several disconnect limits.
// Depends on lsct_pkg and the tracker RTL.

module tb_top;
  import lsct_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned NUM_ROWS    = 22;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned BURST_FAILS = 300;

  // declared from the top bit down, so it lines up with m_axis_tdata[133:0]
  typedef struct packed {
    logic [DATA_W-1:0]  thresh;
    logic [DATA_W-1:0]  analog;
    logic [TREG_W-1:0]  treg;
    logic [AREG_W-1:0]  areg;
    logic [STATE_W-1:0] bits;
    logic [SEQ_W-1:0]   err_total;
    logic [SEQ_W-1:0]   seq;
    logic               conn;
    logic               lost;
    logic [CNT_W-1:0]   active;
    logic [POS_W-1:0]   position;
  } tracker_out_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               ok;
    logic [DATA_W-1:0]  data;
    logic [QUERY_W-1:0] query;
    logic               typed;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   act;
    logic               lost;
    logic               conn;
  } read_row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // tracker state as the predictor sees it
  logic [LIMIT_W-1:0] trk_limit;
  logic [7:0]         trk_consec;
  logic               trk_conn;
  logic               trk_lost;
  logic [SEQ_W-1:0]   trk_seq;
  logic [SEQ_W-1:0]   trk_errs;
  logic [STATE_W-1:0] trk_bits;
  logic [POS_W-1:0]   trk_pos;
  logic [CNT_W-1:0]   trk_active;
  logic [2:0]         trk_ach;
  logic [2:0]         trk_tch;
  logic [DATA_W-1:0]  trk_analog [8];
  logic [DATA_W-1:0]  trk_thresh [8];

  tracker_out_t pending_reports [$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  rx_hold = 0;
  bit           tx_free = 1'b0;
  bit           rx_free = 1'b0;

  // typed rows assume the reset limit of 3
  read_row_t directed_rows [NUM_ROWS] = '{
    '{KIND_UNUSED, 1'b1, 16'hFFFF, 3'd7, 1'b1, 13'sd0,     4'd0, 1'b1, 1'b0},
    '{KIND_STATE,  1'b1, 16'h0000, 3'd0, 1'b1, 13'sd0,     4'd0, 1'b1, 1'b1},
    '{KIND_STATE,  1'b1, 16'h00FF, 3'd1, 1'b1, 13'sd0,     4'd8, 1'b0, 1'b1},
    '{KIND_STATE,  1'b1, 16'h0001, 3'd2, 1'b1, -13'sd3500, 4'd1, 1'b0, 1'b1},
    '{KIND_STATE,  1'b1, 16'h0080, 3'd3, 1'b1, 13'sd3500,  4'd1, 1'b0, 1'b1},
    '{KIND_STATE,  1'b1, 16'h000B, 3'd4, 1'b1, -13'sd2166, 4'd3, 1'b0, 1'b1},
    '{KIND_STATE,  1'b1, 16'h00D0, 3'd5, 1'b1, 13'sd2166,  4'd3, 1'b0, 1'b1},
    '{KIND_STATE,  1'b1, 16'hFF00, 3'd6, 1'b1, 13'sd0,     4'd0, 1'b1, 1'b1},
    '{KIND_ANALOG, 1'b1, 16'hFFFF, 3'd0, 1'b0, 13'sd0,     4'd0, 1'b0, 1'b0},
    '{KIND_ANALOG, 1'b1, 16'h0000, 3'd0, 1'b0, 13'sd0,     4'd0, 1'b0, 1'b0},
    '{KIND_ANALOG, 1'b1, 16'hA5A5, 3'd2, 1'b0, 13'sd0,     4'd0, 1'b0, 1'b0},
    '{KIND_THRESH, 1'b1, 16'hFFFF, 3'd0, 1'b0, 13'sd0,     4'd0, 1'b0, 1'b0},
    '{KIND_THRESH, 1'b1, 16'h5A5A, 3'd1, 1'b0, 13'sd0,     4'd0, 1'b0, 1'b0},
    // three failures in a row reach the limit; the unused kind doesn't count
    '{KIND_STATE,  1'b0, 16'h00FF, 3'd7, 1'b1, 13'sd0,     4'd0, 1'b1, 1'b1},
    '{KIND_ANALOG, 1'b0, 16'hFFFF, 3'd3, 1'b1, 13'sd0,     4'd0, 1'b1, 1'b1},
    '{KIND_UNUSED, 1'b0, 16'h1234, 3'd4, 1'b1, 13'sd0,     4'd0, 1'b1, 1'b1},
    '{KIND_THRESH, 1'b0, 16'h0000, 3'd5, 1'b1, 13'sd0,     4'd0, 1'b1, 1'b0},
    '{KIND_STATE,  1'b1, 16'h0018, 3'd6, 1'b1, 13'sd0,     4'd2, 1'b0, 1'b1},
    '{KIND_THRESH, 1'b1, 16'h0001, 3'd6, 1'b0, 13'sd0,     4'd0, 1'b0, 1'b0},
    '{KIND_ANALOG, 1'b1, 16'h8000, 3'd7, 1'b0, 13'sd0,     4'd0, 1'b0, 1'b0},
    '{KIND_STATE,  1'b1, 16'h00C3, 3'd1, 1'b1, 13'sd0,     4'd4, 1'b0, 1'b1},
    '{KIND_UNUSED, 1'b1, 16'hFFFF, 3'd2, 1'b0, 13'sd0,     4'd0, 1'b0, 1'b0}
  };

  line_sensor_centroid_tracker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned phase_limit(input int unsigned ph);
    case (ph)
      0:       return 1;
      1:       return ERR_SAT;
      2:       return 0;
      3:       return 2;
      4:       return 6;
      5:       return $urandom_range(1, 254);
      6:       return LIMIT_RESET;
      default: return 128;
    endcase
  endfunction

  // applies one read to the tracker state and returns the report it yields
  function automatic tracker_out_t track_read(input logic [KIND_W-1:0] kind,
                                              input logic ok,
                                              input logic [DATA_W-1:0] data,
                                              input logic [QUERY_W-1:0] query);
    tracker_out_t r;
    int sum;
    int n;
    int i;
    if (kind != KIND_UNUSED && !ok) begin
      trk_errs = trk_errs + 1;
      if (trk_consec != ERR_SAT) trk_consec = trk_consec + 8'd1;
      if (trk_consec >= trk_limit) trk_conn = 1'b0;
    end else if (kind == KIND_STATE) begin
      sum = 0;
      n = 0;
      // weights run -3500..3500 in steps of 1000, bit 0 leftmost
      for (i = 0; i < 8; i++) begin
        if (data[i]) begin
          sum += 1000 * i - 3500;
          n++;
        end
      end
      trk_bits   = data[7:0];
      trk_active = CNT_W'(n);
      trk_lost   = (n == 0);
      trk_pos    = (n == 0) ? '0 : POS_W'(sum / n);
      trk_conn   = 1'b1;
      trk_seq    = trk_seq + 1;
      trk_consec = '0;
    end else if (kind == KIND_ANALOG) begin
      trk_analog[trk_ach] = data;
      trk_ach = trk_ach + 3'd1;
    end else if (kind == KIND_THRESH) begin
      trk_thresh[trk_tch] = data;
      trk_tch = trk_tch + 3'd1;
    end
    r.position  = trk_pos;
    r.active    = trk_active;
    r.lost      = trk_lost;
    r.conn      = trk_conn;
    r.seq       = trk_seq;
    r.err_total = trk_errs;
    r.bits      = trk_bits;
    r.areg      = AREG_W'(ANALOG_BASE + 2 * trk_ach);
    r.treg      = TREG_W'(THRESHOLD_BASE + 2 * trk_tch);
    r.analog    = trk_analog[query];
    r.thresh    = trk_thresh[query];
    return r;
  endfunction

  // holds the beat until accepted, then predicts its report
  task automatic send_read(input logic [KIND_W-1:0] kind, input logic ok,
                           input logic [DATA_W-1:0] data,
                           input logic [QUERY_W-1:0] query,
                           output tracker_out_t r);
    s_axis_tdata  <= {5'b0, query, data};
    s_axis_tuser  <= {ok, kind};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = track_read(kind, ok, data, query);
  endtask

  task automatic random_read(inout int unsigned fail_left);
    logic [KIND_W-1:0] kind;
    logic              ok;
    int unsigned       pick;
    tracker_out_t      r;
    pick = $urandom_range(0, 19);
    if (pick < 8) kind = KIND_STATE;
    else if (pick < 13) kind = KIND_ANALOG;
    else if (pick < 18) kind = KIND_THRESH;
    else kind = KIND_UNUSED;
    if (fail_left == 0 && $urandom_range(0, 29) == 0) fail_left = $urandom_range(1, 12);
    if (fail_left != 0) begin
      ok = 1'b0;
      fail_left--;
      if (kind == KIND_UNUSED) kind = KIND_STATE;
    end else begin
      ok = ($urandom_range(0, 9) != 0);
    end
    send_read(kind, ok, DATA_W'($urandom), QUERY_W'($urandom), r);
    pending_reports.push_back(r);
  endtask

  task automatic pace();
    int unsigned g;
    g = tx_free ? 0 : gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : report_check
    tracker_out_t want;
    tracker_out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(tracker_out_t)-1:0];
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report beat: expected none, actual 0x%0h", $time, got);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("position", want.position, got.position);
        check_field("lit_count", want.active, got.active);
        check_field("no_line", want.lost, got.lost);
        check_field("connected", want.conn, got.conn);
        check_field("good_reads", want.seq, got.seq);
        check_field("error_total", want.err_total, got.err_total);
        check_field("state_bits", want.bits, got.bits);
        check_field("next_analog_register", want.areg, got.areg);
        check_field("next_threshold_register", want.treg, got.treg);
        check_field("analog_at_query", want.analog, got.analog);
        check_field("threshold_at_query", want.thresh, got.thresh);
      end
    end
  end

  always @(posedge clk_i) begin : sink_pacing
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_free && $urandom_range(0, 3) == 0) rx_hold = gap_len();
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    tracker_out_t r;
    int unsigned  lim_v;
    int unsigned  fail_left;
    int unsigned  n_items;
    int unsigned  k;
    int unsigned  ph;
    int unsigned  j;
    trk_limit  = LIMIT_RESET;
    trk_consec = '0;
    trk_conn   = 1'b0;
    trk_lost   = 1'b1;
    trk_seq    = '0;
    trk_errs   = '0;
    trk_bits   = '0;
    trk_pos    = '0;
    trk_active = '0;
    trk_ach    = '0;
    trk_tch    = '0;
    for (k = 0; k < 8; k++) begin
      trk_analog[k] = '0;
      trk_thresh[k] = '0;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < NUM_ROWS; k++) begin
      send_read(directed_rows[k].kind, directed_rows[k].ok, directed_rows[k].data,
                directed_rows[k].query, r);
      if (directed_rows[k].typed) begin
        r.position = directed_rows[k].pos;
        r.active   = directed_rows[k].act;
        r.lost     = directed_rows[k].lost;
        r.conn     = directed_rows[k].conn;
      end
      pending_reports.push_back(r);
      pace();
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // limit only changes with nothing in flight
      drain();
      lim_v = phase_limit(ph);
      cfg_wdata_i <= LIMIT_W'(lim_v);
      cfg_we_i    <= 1'b1;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      trk_limit = LIMIT_W'(lim_v);
      tx_free = (ph % 3 == 1);
      rx_free = (ph % 3 == 2);
      // at the top limit, a long failure run drives the consecutive-failure count into saturation
      fail_left = (lim_v == ERR_SAT) ? BURST_FAILS : 0;
      n_items   = (lim_v == ERR_SAT) ? 330 : 230;
      for (j = 0; j < n_items; j++) begin
        random_read(fail_left);
        pace();
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[line_sensor_centroid_tracker_top.f]
hw/rtl/lsct_pkg.sv
hw/rtl/lsct_centroid.sv
hw/rtl/line_sensor_centroid_tracker_top.sv
test/tb_top.sv
